### src/lcd_rect_fill_stream_core_defines.svh
// Assertion macros shared by the rectangle fill stream core.
`ifndef LCD_RECT_FILL_STREAM_CORE_DEFINES_SVH
`define LCD_RECT_FILL_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LRFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd_rfs: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LRFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd_rfs: next-cycle check failed");

`endif

### src/lcd_rfs_pkg.sv
// Shared types and constants of the rectangle fill stream core.
package lcd_rfs_pkg;

    // Default screen sides in pixels.
    localparam int SHORT_SIDE_DEF = 240;
    localparam int LONG_SIDE_DEF  = 320;

    // Width of a clipped dimension; covers every allowed screen side.
    localparam int DIM_W = 12;

    // Entries of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Display command bytes.
    localparam logic [7:0] BYTE_COL_ADDR = 8'h2A;
    localparam logic [7:0] BYTE_ROW_ADDR = 8'h2B;
    localparam logic [7:0] BYTE_MEM_WR   = 8'h2C;

    // Request status codes.
    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_ACCEPTED   = 2'd1,
        ST_OFF_SCREEN = 2'd2,
        ST_BUSY       = 2'd3
    } status_t;

    // One classified word as it waits in the queue.
    typedef struct packed {
        logic             is_tick;
        logic             off_screen;
        logic [15:0]      col_start;
        logic [15:0]      col_end;
        logic [15:0]      row_start;
        logic [15:0]      row_end;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [15:0]      color;
    } q_entry_t;

endpackage

### src/lcd_rfs_if.sv
// Stream and configuration interfaces of the rectangle fill stream core.
interface lcd_rfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] orientation;

    modport source (output valid, output orientation, input ready);
    modport sink   (input valid, input orientation, output ready);
endinterface

interface lcd_rfs_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;

    modport source (output valid, output command, output rect_x, output rect_y,
                    output rect_width, output rect_height, output fill_color,
                    input ready);
    modport sink   (input valid, input command, input rect_x, input rect_y,
                    input rect_width, input rect_height, input fill_color,
                    output ready);
endinterface

interface lcd_rfs_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] request_status;
    logic       byte_valid;
    logic [7:0] link_byte;
    logic       is_data;
    logic       last_byte;

    modport source (output valid, output request_status, output byte_valid,
                    output link_byte, output is_data, output last_byte,
                    input ready);
    modport sink   (input valid, input request_status, input byte_valid,
                    input link_byte, input is_data, input last_byte,
                    output ready);
endinterface

### src/lcd_rfs_front.sv
// Front part: holds the orientation, classifies words and clips fill requests.
module lcd_rfs_front #(
    parameter int SHORT_SIDE = lcd_rfs_pkg::SHORT_SIDE_DEF,
    parameter int LONG_SIDE  = lcd_rfs_pkg::LONG_SIDE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lcd_rfs_cfg_if.sink           cfg,
    lcd_rfs_req_if.sink           req,
    output lcd_rfs_pkg::q_entry_t push_entry,
    output logic                  push_valid,
    input  logic                  push_ready
);
    import lcd_rfs_pkg::*;

    localparam logic [DIM_W-1:0] SHORT_V = DIM_W'(SHORT_SIDE);
    localparam logic [DIM_W-1:0] LONG_V  = DIM_W'(LONG_SIDE);

    logic [1:0]       orient_reg;
    logic [DIM_W-1:0] scr_w;
    logic [DIM_W-1:0] scr_h;
    logic [16:0]      sum_x;
    logic [16:0]      sum_y;
    logic             clip_x;
    logic             clip_y;

    // Orientation register; the write port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= 2'd0;
        end
        else if (cfg.valid)
        begin
            orient_reg <= cfg.orientation;
        end
    end

    // Odd orientations turn the screen on its side.
    assign scr_w = orient_reg[0] ? LONG_V : SHORT_V;
    assign scr_h = orient_reg[0] ? SHORT_V : LONG_V;

    // A nonzero size whose far edge passes the screen gets cut at the edge.
    assign sum_x  = 17'(req.rect_x) + 17'(req.rect_width);
    assign sum_y  = 17'(req.rect_y) + 17'(req.rect_height);
    assign clip_x = (req.rect_width != 16'd0) && (sum_x > 17'(scr_w));
    assign clip_y = (req.rect_height != 16'd0) && (sum_y > 17'(scr_h));

    // Build the queue word.
    always_comb
    begin
        push_entry.is_tick    = (req.command == CMD_TICK);
        push_entry.off_screen = (req.rect_x >= 16'(scr_w)) || (req.rect_y >= 16'(scr_h));
        push_entry.col_start  = req.rect_x;
        push_entry.row_start  = req.rect_y;
        push_entry.col_end    = clip_x ? (16'(scr_w) - 16'd1)
                                       : (req.rect_x + req.rect_width - 16'd1);
        push_entry.row_end    = clip_y ? (16'(scr_h) - 16'd1)
                                       : (req.rect_y + req.rect_height - 16'd1);
        push_entry.width      = clip_x ? (scr_w - req.rect_x[DIM_W-1:0])
                                       : req.rect_width[DIM_W-1:0];
        push_entry.height     = clip_y ? (scr_h - req.rect_y[DIM_W-1:0])
                                       : req.rect_height[DIM_W-1:0];
        push_entry.color      = req.fill_color;
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

### src/lcd_rfs_queue.sv
// Short queue of classified words between the front and the back.
module lcd_rfs_queue #(
    parameter int DEPTH = lcd_rfs_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcd_rfs_pkg::q_entry_t push_entry,
    input  logic                  push_valid,
    output logic                  push_ready,
    output lcd_rfs_pkg::q_entry_t pop_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready
);
    import lcd_rfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage; entries carry payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### src/lcd_rfs_back.sv
// Back part: runs the fill sequence and drives the registered result word.
module lcd_rfs_back #(
    parameter int SHORT_SIDE = lcd_rfs_pkg::SHORT_SIDE_DEF,
    parameter int LONG_SIDE  = lcd_rfs_pkg::LONG_SIDE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcd_rfs_pkg::q_entry_t pop_entry,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    lcd_rfs_rsp_if.source         rsp
);
    import lcd_rfs_pkg::*;

    // Pixel byte counter holds up to two bytes per screen pixel.
    localparam int PIX_W = $clog2(2 * SHORT_SIDE * LONG_SIDE + 1);

    // Position within the address phase; the last member marks pixel bytes.
    typedef enum logic [3:0] {
        HDR_CASET  = 4'd0,
        HDR_XS_HI  = 4'd1,
        HDR_XS_LO  = 4'd2,
        HDR_XE_HI  = 4'd3,
        HDR_XE_LO  = 4'd4,
        HDR_PASET  = 4'd5,
        HDR_YS_HI  = 4'd6,
        HDR_YS_LO  = 4'd7,
        HDR_YE_HI  = 4'd8,
        HDR_YE_LO  = 4'd9,
        HDR_RAMWR  = 4'd10,
        HDR_PIXELS = 4'd11
    } hdr_t;

    logic               busy_reg,  busy_next;
    hdr_t               hdr_reg,   hdr_next;
    logic [15:0]        col_start_reg, col_start_next;
    logic [15:0]        col_end_reg,   col_end_next;
    logic [15:0]        row_start_reg, row_start_next;
    logic [15:0]        row_end_reg,   row_end_next;
    logic [15:0]        color_reg,     color_next;
    logic [PIX_W-1:0]   pix_reg,   pix_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg,    status_next;
    logic               bvalid_reg,    bvalid_next;
    logic [7:0]         byte_reg,      byte_next;
    logic               data_reg,      data_next;
    logic               last_reg,      last_next;
    logic [2*DIM_W-1:0] area;
    logic [PIX_W-1:0]   pix_dec;
    logic               step;

    // Take a word whenever the result register is free or being emptied.
    assign step      = pop_valid && (!out_valid_reg || rsp.ready);
    assign pop_ready = step;

    assign area    = pop_entry.width * pop_entry.height;
    assign pix_dec = (pix_reg != '0) ? (pix_reg - PIX_W'(1)) : pix_reg;

    // Next state and result of one word.
    always_comb
    begin
        busy_next      = busy_reg;
        hdr_next       = hdr_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        color_next     = color_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        bvalid_next    = bvalid_reg;
        byte_next      = byte_reg;
        data_next      = data_reg;
        last_next      = last_reg;

        if (step)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_NONE;
            bvalid_next    = 1'b0;
            byte_next      = 8'h00;
            data_next      = 1'b0;
            last_next      = 1'b0;

            if (!pop_entry.is_tick)
            begin
                // Fill request: refuse while busy, drop when off screen.
                if (busy_reg)
                begin
                    status_next = ST_BUSY;
                end
                else if (pop_entry.off_screen)
                begin
                    status_next = ST_OFF_SCREEN;
                end
                else
                begin
                    status_next    = ST_ACCEPTED;
                    col_start_next = pop_entry.col_start;
                    col_end_next   = pop_entry.col_end;
                    row_start_next = pop_entry.row_start;
                    row_end_next   = pop_entry.row_end;
                    color_next     = pop_entry.color;
                    pix_next       = PIX_W'({area, 1'b0});
                    hdr_next       = HDR_CASET;
                    busy_next      = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                bvalid_next = 1'b1;
                data_next   = 1'b1;
                if (hdr_reg != HDR_PIXELS)
                begin
                    // Address window bytes, then the memory write command.
                    unique case (hdr_reg)
                        HDR_CASET:
                        begin
                            byte_next = BYTE_COL_ADDR;
                            data_next = 1'b0;
                        end
                        HDR_XS_HI: byte_next = col_start_reg[15:8];
                        HDR_XS_LO: byte_next = col_start_reg[7:0];
                        HDR_XE_HI: byte_next = col_end_reg[15:8];
                        HDR_XE_LO: byte_next = col_end_reg[7:0];
                        HDR_PASET:
                        begin
                            byte_next = BYTE_ROW_ADDR;
                            data_next = 1'b0;
                        end
                        HDR_YS_HI: byte_next = row_start_reg[15:8];
                        HDR_YS_LO: byte_next = row_start_reg[7:0];
                        HDR_YE_HI: byte_next = row_end_reg[15:8];
                        HDR_YE_LO: byte_next = row_end_reg[7:0];
                        default:
                        begin
                            byte_next = BYTE_MEM_WR;
                            data_next = 1'b0;
                        end
                    endcase
                    hdr_next = hdr_t'(4'(hdr_reg) + 4'd1);
                    // An empty rectangle ends on the memory write command.
                    if (hdr_reg == HDR_RAMWR && pix_reg == '0)
                    begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                        hdr_next  = HDR_CASET;
                    end
                end
                else
                begin
                    // Pixel bytes: an even count left sends the high byte.
                    byte_next = pix_reg[0] ? color_reg[7:0] : color_reg[15:8];
                    pix_next  = pix_dec;
                    if (pix_dec == '0)
                    begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                        hdr_next  = HDR_CASET;
                    end
                end
            end
        end
    end

    // Sequence state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            hdr_reg       <= HDR_CASET;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
            color_reg     <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_NONE;
            bvalid_reg    <= 1'b0;
            byte_reg      <= 8'h00;
            data_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            hdr_reg       <= hdr_next;
            col_start_reg <= col_start_next;
            col_end_reg   <= col_end_next;
            row_start_reg <= row_start_next;
            row_end_reg   <= row_end_next;
            color_reg     <= color_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            bvalid_reg    <= bvalid_next;
            byte_reg      <= byte_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.request_status = status_reg;
    assign rsp.byte_valid     = bvalid_reg;
    assign rsp.link_byte      = byte_reg;
    assign rsp.is_data        = data_reg;
    assign rsp.last_byte      = last_reg;

endmodule

### src/lcd_rect_fill_stream_core.sv
// Rectangle fill core: clips a fill request and streams the link bytes for it.
// Every accepted word (a fill request or a tick) yields exactly one result word,
// and the core takes one word per clock cycle when the result side keeps up.
// A result is presented once its word has passed through the two-entry queue
// behind the clipping front end and then the sequencer's output register,
// which it enters whenever that register is free or being emptied. Fill
// requests take the same path as ticks, since the clip and the pixel-count
// multiply each fit in one register stage. The queue absorbs a stalled result
// side, so the input stays ready until both entries and the output register
// are occupied. Orientation changes are to be written by the user only while
// no word is in flight; the core itself does not enforce this.
`include "lcd_rect_fill_stream_core_defines.svh"

module lcd_rect_fill_stream_core #(
    parameter int SHORT_SIDE = lcd_rfs_pkg::SHORT_SIDE_DEF,
    parameter int LONG_SIDE  = lcd_rfs_pkg::LONG_SIDE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lcd_rfs_cfg_if.sink   cfg,
    lcd_rfs_req_if.sink   req,
    lcd_rfs_rsp_if.source rsp
);
    import lcd_rfs_pkg::*;

    q_entry_t push_entry;
    q_entry_t pop_entry;
    logic     push_valid;
    logic     push_ready;
    logic     pop_valid;
    logic     pop_ready;

    // Classify and clip.
    lcd_rfs_front #(
        .SHORT_SIDE (SHORT_SIDE),
        .LONG_SIDE  (LONG_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Decoupling queue.
    lcd_rfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Fill sequencer.
    lcd_rfs_back #(
        .SHORT_SIDE (SHORT_SIDE),
        .LONG_SIDE  (LONG_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

    // An accepted word is waiting in the queue in the following cycle.
    `LRFS_ASSERT_NEXT(a_accept_lands, req.valid && req.ready, pop_valid)

    // A last mark only ever rides on a byte that is really sent.
    `LRFS_ASSERT_NOW(a_last_has_byte, rsp.valid && rsp.last_byte, rsp.byte_valid)

    // Command bytes are only the three window and write commands.
    `LRFS_ASSERT_NOW(a_cmd_byte_code, rsp.valid && rsp.byte_valid && !rsp.is_data,
        rsp.link_byte == BYTE_COL_ADDR || rsp.link_byte == BYTE_ROW_ADDR ||
        rsp.link_byte == BYTE_MEM_WR)

endmodule
